>>> rtl/acte_pkg.sv
package acte_pkg;

  // Key length codes as written to register 0.
  localparam logic [1:0] KL_128 = 2'd0;
  localparam logic [1:0] KL_192 = 2'd1;
  localparam logic [1:0] KL_256 = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_LEN = 3'd0;
  localparam logic [2:0] REG_KEY_W3  = 3'd4;

  localparam int unsigned RowCount  = 16;
  localparam logic [4:0]  FullCount = 5'd16;

  // Source of the block that enters the cipher.
  typedef enum logic [1:0] {
    SRC_CHAIN = 2'd0,
    SRC_ZERO  = 2'd1,
    SRC_LAST  = 2'd2
  } src_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       exp_step;
    logic [5:0] exp_idx;
    logic [2:0] exp_mod;
    logic [3:0] rd_row;
    logic       blk_capture;
    logic       aes_load;
    src_sel_e   src_sel;
    logic       aes_round;
    logic       aes_final;
    logic       chain_store;
    logic       chain_clear;
    logic       subkey_store;
    logic       out_load;
    logic       out_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] key_len;
    logic       blk_full;
    logic       blk_last;
  } status_t;

  // The forward S-box, entry 0 in the top byte.
  localparam logic [2047:0] SBOX_FLAT = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_FLAT[2047 - 8 * int'(x) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Words in the key; the unused code acts as a 256 bit key.
  function automatic logic [3:0] nk_of(input logic [1:0] kl);
    logic [3:0] nk;
    unique case (kl)
      KL_128:  nk = 4'd4;
      KL_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    return nk;
  endfunction

endpackage

>>> rtl/acte_ctrl.sv
module acte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_hit_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  acte_pkg::status_t sts_i,
  output acte_pkg::cmd_t    cmd_o
);
  import acte_pkg::*;

  typedef enum logic [5:0] {
    ST_EXPAND = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DISP   = 6'b000100,
    ST_SK     = 6'b001000,
    ST_MSG    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic [2:0] mod_q, mod_d;
  logic [3:0] rnd_q, rnd_d;
  logic       sk_ready_q, sk_ready_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  logic [3:0] nk, nr;
  logic [5:0] total;
  logic       in_fire;
  logic       run_end;

  assign nk      = nk_of(sts_i.key_len);
  assign nr      = nk + 4'd6;
  assign total   = {nr, 2'b00} + 6'd4;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign run_end     = (rnd_q == nr + 4'd1);

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mod_d       = mod_q;
    rnd_d       = rnd_q;
    sk_ready_d  = sk_ready_q;
    err_d       = err_q;
    cmd_o       = '0;
    cmd_o.src_sel     = SRC_CHAIN;
    cmd_o.exp_idx     = idx_q;
    cmd_o.exp_mod     = mod_q;
    cmd_o.rd_row      = rnd_q;
    cmd_o.blk_capture = in_fire;
    unique case (state_q)
      ST_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        idx_d = idx_q + 6'd1;
        mod_d = ({1'b0, mod_q} == nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
        if (idx_q == total - 6'd1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        rnd_d = 4'd0;
        if (!sts_i.blk_last && !sts_i.blk_full) begin
          cmd_o.chain_clear = 1'b1;
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else if (sts_i.blk_last && !sk_ready_q) begin
          state_d = ST_SK;
        end else begin
          state_d = ST_MSG;
        end
      end
      ST_SK, ST_MSG: begin
        if (state_q == ST_SK) begin
          cmd_o.src_sel = SRC_ZERO;
        end else if (sts_i.blk_last) begin
          cmd_o.src_sel = SRC_LAST;
        end
        cmd_o.aes_load  = (rnd_q == 4'd1);
        cmd_o.aes_round = (rnd_q >= 4'd2);
        cmd_o.aes_final = run_end;
        rnd_d = rnd_q + 4'd1;
        if (run_end) begin
          rnd_d = 4'd0;
          if (state_q == ST_SK) begin
            cmd_o.subkey_store = 1'b1;
            sk_ready_d = 1'b1;
            state_d    = ST_MSG;
          end else if (sts_i.blk_last) begin
            cmd_o.chain_clear = 1'b1;
            err_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            cmd_o.chain_store = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = err_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // A key write restarts the key schedule and drops the message.
    if (cfg_hit_i) begin
      state_d    = ST_EXPAND;
      idx_d      = 6'd0;
      mod_d      = 3'd0;
      sk_ready_d = 1'b0;
      cmd_o.chain_clear = 1'b1;
    end
  end

  // Output request flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXPAND;
      idx_q       <= 6'd0;
      mod_q       <= 3'd0;
      rnd_q       <= 4'd0;
      sk_ready_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mod_q       <= mod_d;
      rnd_q       <= rnd_d;
      sk_ready_q  <= sk_ready_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPAND) |-> (idx_q < total))
    else $error("key schedule index out of range");
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SK || state_q == ST_MSG) |-> (rnd_q <= nr + 4'd1))
    else $error("round counter out of range");
  a_sk_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_ready_q) |-> ($past(state_q) == ST_SK))
    else $error("subkey marked ready without its encryption");
`endif

endmodule

>>> rtl/acte_datapath.sv
module acte_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic [127:0]      in_block_i,
  input  logic [4:0]        in_count_i,
  input  logic              in_last_i,
  input  acte_pkg::cmd_t    cmd_i,
  output acte_pkg::status_t sts_o,
  output logic [127:0]      out_tag_o,
  output logic              out_err_o
);
  import acte_pkg::*;

  logic [1:0]   key_len_q;
  logic [63:0]  key_q [4];
  logic [127:0] chain_q, l_q, blk_q, st_q, rd_q, out_q;
  logic [4:0]   n_q;
  logic         last_q, out_err_q;
  logic [127:0] mem [RowCount];
  logic [31:0]  win_q [8];
  logic [95:0]  rbuf_q;
  logic [7:0]   rcon_q;
  logic [3:0]   nk;
  logic [31:0]  kw, t, old, f, w;
  logic [127:0] k1, k2, pad, src, st_in;
  logic [4:0]   n_sat;

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  // One AES round without the key addition.
  function automatic logic [127:0] aes_rnd(input logic [127:0] s, input logic fin);
    logic [7:0]   b [16];
    logic [7:0]   u [16];
    logic [7:0]   o [16];
    logic [7:0]   al;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) begin
      b[k] = s[127 - 8 * k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        u[4 * c + i] = sbox(b[4 * ((c + i) % 4) + i]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      al = u[4 * c] ^ u[4 * c + 1] ^ u[4 * c + 2] ^ u[4 * c + 3];
      for (int i = 0; i < 4; i++) begin
        o[4 * c + i] = fin ? u[4 * c + i] :
          u[4 * c + i] ^ al ^ xtime(u[4 * c + i] ^ u[4 * c + ((i + 1) % 4)]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[127 - 8 * k -: 8] = o[k];
    end
    return r;
  endfunction

  // Key schedule word generation.
  assign nk  = nk_of(key_len_q);
  assign kw  = cmd_i.exp_idx[0] ? key_q[cmd_i.exp_idx[2:1]][31:0]
                                : key_q[cmd_i.exp_idx[2:1]][63:32];
  assign t   = win_q[7];
  always_comb begin
    unique case (nk)
      4'd4:    old = win_q[4];
      4'd6:    old = win_q[2];
      default: old = win_q[0];
    endcase
    if (cmd_i.exp_mod == 3'd0) begin
      f = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && cmd_i.exp_mod == 3'd4) begin
      f = sub_word(t);
    end else begin
      f = t;
    end
    w = (cmd_i.exp_idx < {2'b00, nk}) ? kw : old ^ f;
  end

  // Key schedule registers and round key memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      for (int j = 0; j < 7; j++) begin
        win_q[j] <= win_q[j + 1];
      end
      win_q[7] <= w;
      rbuf_q   <= {rbuf_q[63:0], w};
      if (cmd_i.exp_idx == 6'd0) begin
        rcon_q <= 8'h01;
      end else if (cmd_i.exp_mod == 3'd0 && cmd_i.exp_idx >= {2'b00, nk}) begin
        rcon_q <= xtime(rcon_q);
      end
      if (cmd_i.exp_idx[1:0] == 2'b11) begin
        mem[cmd_i.exp_idx[5:2]] <= {rbuf_q, w};
      end
    end
    rd_q <= mem[cmd_i.rd_row];
  end

  // Last block padding and subkey selection.
  assign k1 = dbl(l_q);
  assign k2 = dbl(k1);
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      if (k < int'(n_q)) begin
        pad[127 - 8 * k -: 8] = blk_q[127 - 8 * k -: 8];
      end else if (k == int'(n_q)) begin
        pad[127 - 8 * k -: 8] = 8'h80;
      end else begin
        pad[127 - 8 * k -: 8] = 8'h00;
      end
    end
    unique case (cmd_i.src_sel)
      SRC_ZERO: src = '0;
      SRC_LAST: src = chain_q ^ ((n_q == FullCount) ? (blk_q ^ k1) : (pad ^ k2));
      default:  src = chain_q ^ blk_q;
    endcase
    st_in = cmd_i.aes_load ? (src ^ rd_q) : (aes_rnd(st_q, cmd_i.aes_final) ^ rd_q);
  end

  assign n_sat = (in_count_i > FullCount) ? FullCount : in_count_i;

  // Block, cipher state, subkey and result registers.
  // The subkey is taken from the output of the final round in that same cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_capture) begin
      blk_q  <= in_block_i;
      n_q    <= n_sat;
      last_q <= in_last_i;
    end
    if (cmd_i.aes_load || cmd_i.aes_round) begin
      st_q <= st_in;
    end
    if (cmd_i.subkey_store) begin
      l_q <= st_in;
    end
    if (cmd_i.out_load) begin
      out_q     <= cmd_i.out_err ? '0 : st_q;
      out_err_q <= cmd_i.out_err;
    end
  end

  // Key registers and chaining value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KL_128;
      for (int j = 0; j < 4; j++) begin
        key_q[j] <= '0;
      end
      chain_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_KEY_LEN) begin
          key_len_q <= cfg_data_i[1:0];
        end else if (cfg_index_i <= REG_KEY_W3) begin
          key_q[2'(cfg_index_i - 3'd1)] <= cfg_data_i;
        end
      end
      if (cmd_i.chain_clear) begin
        chain_q <= '0;
      end else if (cmd_i.chain_store) begin
        chain_q <= st_in;
      end
    end
  end

  assign sts_o.key_len  = key_len_q;
  assign sts_o.blk_full = (n_q == FullCount);
  assign sts_o.blk_last = last_q;
  assign out_tag_o = out_q;
  assign out_err_o = out_err_q;

endmodule

>>> rtl/aes_cmac_tag_engine.sv
// Channel | Direction | Handshake                 | Payload
// s_axis  | in        | s_axis_tvalid/tready      | tdata: block_high, block_low, byte_count
//         |           |                           | tlast: is_last
// m_axis  | out       | m_axis_tvalid/tready      | tdata: tag_high, tag_low; tuser: status
// cfg     | in        | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// A full inner block runs through the iterated round unit, one round per cycle;
// a last block then also loads the tag, and a short inner block skips the rounds
// and ends with the error status. The first last block after a key write first
// encrypts the zero block for L. After reset and after each key write the schedule
// makes 4 * (Nr + 1) words (44, 52 or 60), one word a cycle, taking no request meanwhile.
// A finished result waits in the output register; a stalled output holds the
// engine only when the next result is ready.
module aes_cmac_tag_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // block_high, block_low, byte_count, zero fill
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // tag_high, tag_low
  output logic         m_axis_tuser,  // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import acte_pkg::*;

  cmd_t         cmd;
  status_t      sts;
  logic         cfg_hit;
  logic [127:0] tag;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i & (cfg_index_i <= REG_KEY_W3);

  acte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_hit_i   (cfg_hit),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acte_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_hit),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_block_i  ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .in_count_i  (s_axis_tdata[132:128]),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tag_o   (tag),
    .out_err_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {tag[63:0], tag[127:64]};

endmodule
